@@ rtl/slpa_pkg.sv @@
// Shared types, codes and defaults of the static link pool allocator.
// No dependencies; every other file of the block but slpa_ram imports this package.
package slpa_pkg;

    localparam int POOL_DEPTH_DEF = 16;
    localparam int SIZE_RST_VAL   = 16;
    localparam int APB_AW         = 3;
    localparam int APB_DW         = 32;

    localparam logic [1:0] FUNC_ALLOC = 2'd0;
    localparam logic [1:0] FUNC_FREE  = 2'd1;
    localparam logic [1:0] FUNC_GET   = 2'd2;
    localparam logic [1:0] FUNC_NEXT  = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam logic REG_POOL_SIZE = 1'b0;

    typedef struct packed {
        logic [1:0] func;
        logic [4:0] position;
    } cmd_t;

    typedef struct packed {
        logic [3:0] slot_index;
        logic [1:0] status;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ALLOC_RD,
        ST_ALLOC_WR,
        ST_WALK
    } state_t;

    typedef struct packed {
        logic cfg_wr;
        logic go_alloc;
        logic go_walk;
        logic init_last;
        logic walk_last;
    } seq_in_t;

    typedef struct packed {
        logic busy;
        logic init_step;
        logic alloc_rd;
        logic alloc_wr;
        logic walk_step;
    } seq_out_t;

endpackage

@@ rtl/slpa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module slpa_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/slpa_seq.sv @@
// Sequencer of the allocator: link sweep, alloc steps and link walk.
// Depends on slpa_pkg.
module slpa_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  slpa_pkg::seq_in_t  sin,
    output slpa_pkg::seq_out_t sout
);
    import slpa_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (sin.init_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (sin.go_alloc)
                begin
                    state_next = ST_ALLOC_RD;
                end
                else if (sin.go_walk)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_ALLOC_RD: state_next = ST_ALLOC_WR;
            ST_ALLOC_WR: state_next = ST_IDLE;
            ST_WALK:
            begin
                if (sin.walk_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
        if (sin.cfg_wr)
        begin
            state_next = ST_INIT;
        end
    end

    always_comb
    begin
        sout = '0;
        case (state_reg)
            ST_INIT:
            begin
                sout.busy      = 1'b1;
                sout.init_step = 1'b1;
            end
            ST_IDLE: sout.busy = 1'b0;
            ST_ALLOC_RD:
            begin
                sout.busy     = 1'b1;
                sout.alloc_rd = 1'b1;
            end
            ST_ALLOC_WR:
            begin
                sout.busy     = 1'b1;
                sout.alloc_wr = 1'b1;
            end
            ST_WALK:
            begin
                sout.busy      = 1'b1;
                sout.walk_step = 1'b1;
            end
            default: sout.busy = 1'b1;
        endcase
    end

endmodule

@@ rtl/static_link_pool_allocator_core.sv @@
// Static link pool allocator: top level with link RAM, datapath and APB register.
// Depends on slpa_pkg, slpa_ram and slpa_seq.
//
// A command word is taken when start is high and busy is low; its result word
// appears on rsp for exactly one cycle with done high, and the receiver cannot
// stall it. Free and every rejected command give their result in the cycle after
// they are taken. Alloc reads the free head's link when taken, then makes two link
// writes through the single RAM write port. Get and next walk up to pool_size + 1
// links, one registered link RAM read per link. After reset and after every
// pool_size write the block sweeps pool_size entries of the link RAM (16 after
// reset), one entry per cycle, with busy high.
module static_link_pool_allocator_core #(
    parameter int POOL_DEPTH = slpa_pkg::POOL_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  slpa_pkg::cmd_t             cmd,
    output logic                       done,
    output slpa_pkg::rsp_t             rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [slpa_pkg::APB_AW-1:0] paddr,
    input  logic [slpa_pkg::APB_DW-1:0] pwdata,
    output logic [slpa_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import slpa_pkg::*;

    localparam int LW       = $clog2(POOL_DEPTH);
    localparam int SIZE_RST = (POOL_DEPTH < SIZE_RST_VAL) ? POOL_DEPTH : SIZE_RST_VAL;

    seq_in_t  sin;
    seq_out_t sout;

    logic [4:0]    size_reg;
    logic [LW-1:0] free_head_reg;
    logic [LW-1:0] tail_reg;
    logic [4:0]    count_reg;
    logic [4:0]    init_idx_reg;
    logic [5:0]    remain_reg;
    logic          done_reg;
    rsp_t          rsp_reg;

    logic          cfg_wr;
    logic [4:0]    size_wr;
    logic          accept;
    logic          alloc_full;
    logic          free_zero;
    logic          free_range;
    logic          walk_range;
    logic [5:0]    walk_steps;
    logic          do_free;

    logic          ram_we;
    logic [LW-1:0] ram_waddr;
    logic [LW-1:0] ram_wdata;
    logic [LW-1:0] ram_raddr;
    logic [LW-1:0] ram_rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_POOL_SIZE);
    assign prdata = (paddr[2] == REG_POOL_SIZE) ? APB_DW'(size_reg) : '0;

    always_comb
    begin
        size_wr = pwdata[4:0];
        if (size_wr == 5'd0)
        begin
            size_wr = 5'd1;
        end
        else if (int'(size_wr) > POOL_DEPTH)
        begin
            size_wr = 5'(POOL_DEPTH);
        end
    end

    assign busy   = sout.busy || cfg_wr;
    assign accept = start && !busy;

    assign alloc_full = ({1'b0, count_reg} + 6'd1) > {1'b0, size_reg};
    assign free_zero  = (count_reg == 5'd0);
    assign free_range = (cmd.position >= size_reg);
    assign walk_range = (cmd.position > size_reg);
    assign walk_steps = (cmd.func == FUNC_GET) ? {1'b0, cmd.position}
                                               : {1'b0, cmd.position} + 6'd1;
    assign do_free    = accept && (cmd.func == FUNC_FREE) && !free_zero && !free_range;

    assign sin.cfg_wr    = cfg_wr;
    assign sin.go_alloc  = accept && (cmd.func == FUNC_ALLOC) && !alloc_full;
    assign sin.go_walk   = accept && (cmd.func == FUNC_GET || cmd.func == FUNC_NEXT)
                           && !walk_range && (walk_steps != 6'd0);
    assign sin.init_last = ({1'b0, init_idx_reg} + 6'd1) == {1'b0, size_reg};
    assign sin.walk_last = (remain_reg == 6'd0);

    slpa_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .sin   (sin),
        .sout  (sout)
    );

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = tail_reg;
        ram_wdata = '0;
        if (sout.init_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = LW'(init_idx_reg);
            ram_wdata = sin.init_last ? '0 : LW'(init_idx_reg + 5'd1);
        end
        else if (do_free)
        begin
            ram_we    = 1'b1;
            ram_waddr = LW'(cmd.position);
            ram_wdata = free_head_reg;
        end
        else if (sout.alloc_rd)
        begin
            ram_we    = 1'b1;
            ram_wdata = free_head_reg;
        end
        else if (sout.alloc_wr)
        begin
            ram_we = 1'b1;
        end
    end

    assign ram_raddr = sout.walk_step ? ram_rdata : (sin.go_alloc ? free_head_reg : '0);

    slpa_ram #(
        .WIDTH (LW),
        .DEPTH (POOL_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= 5'(SIZE_RST);
            free_head_reg <= '0;
            tail_reg      <= '0;
            count_reg     <= 5'd1;
            init_idx_reg  <= '0;
            remain_reg    <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_wr)
            begin
                size_reg      <= size_wr;
                free_head_reg <= '0;
                tail_reg      <= '0;
                count_reg     <= 5'd1;
                init_idx_reg  <= '0;
            end
            else if (sout.init_step)
            begin
                init_idx_reg <= init_idx_reg + 5'd1;
            end
            else if (accept)
            begin
                case (cmd.func)
                    FUNC_ALLOC: done_reg <= alloc_full;
                    FUNC_FREE:
                    begin
                        done_reg <= 1'b1;
                        if (do_free)
                        begin
                            free_head_reg <= LW'(cmd.position);
                            count_reg     <= count_reg - 5'd1;
                        end
                    end
                    default:
                    begin
                        done_reg   <= walk_range || (walk_steps == 6'd0);
                        remain_reg <= walk_steps - 6'd1;
                    end
                endcase
            end
            else if (sout.alloc_rd)
            begin
                free_head_reg <= ram_rdata;
                tail_reg      <= free_head_reg;
            end
            else if (sout.alloc_wr)
            begin
                count_reg <= count_reg + 5'd1;
                done_reg  <= 1'b1;
            end
            else if (sout.walk_step)
            begin
                remain_reg <= remain_reg - 6'd1;
                done_reg   <= sin.walk_last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg.slot_index <= 4'd0;
            case (cmd.func)
                FUNC_ALLOC: rsp_reg.status <= STATUS_RANGE;
                FUNC_FREE:
                begin
                    if (free_zero)
                    begin
                        rsp_reg.status <= STATUS_EMPTY;
                    end
                    else if (free_range)
                    begin
                        rsp_reg.status <= STATUS_RANGE;
                    end
                    else
                    begin
                        rsp_reg.status <= STATUS_OK;
                    end
                end
                default: rsp_reg.status <= walk_range ? STATUS_RANGE : STATUS_OK;
            endcase
        end
        else if (sout.alloc_wr)
        begin
            rsp_reg.slot_index <= 4'(tail_reg);
            rsp_reg.status     <= STATUS_OK;
        end
        else if (sout.walk_step)
        begin
            rsp_reg.slot_index <= 4'(ram_rdata);
            rsp_reg.status     <= STATUS_OK;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

@@ rtl/slpa_check.sv @@
// Port-level assertions for the static link pool allocator, bound to the top level.
// Depends on slpa_pkg and static_link_pool_allocator_core.
module slpa_check (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input slpa_pkg::cmd_t              cmd,
    input logic                        done,
    input slpa_pkg::rsp_t              rsp,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [slpa_pkg::APB_AW-1:0] paddr
);
    import slpa_pkg::*;

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.status == STATUS_OK || rsp.status == STATUS_RANGE
                  || rsp.status == STATUS_EMPTY))
        else $error("undefined status code");

    a_error_slot: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status != STATUS_OK |-> rsp.slot_index == 4'd0)
        else $error("failed command returned a nonzero slot");

    a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr[2] == REG_POOL_SIZE |=> busy)
        else $error("pool size write did not start the link sweep");

    a_free_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd.func == FUNC_FREE |=> done && !busy)
        else $error("free did not finish in one cycle");

endmodule

bind static_link_pool_allocator_core slpa_check u_slpa_check (.*);

@@ dv/slpa_checker.sv @@
// Checker for the static link pool allocator: keeps its own copy of the link pool,
// predicts each result word from accepted commands and pool size writes, and compares.
// Depends on slpa_pkg.
module slpa_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  slpa_pkg::cmd_t                cmd,
    input  logic                          done,
    input  slpa_pkg::rsp_t                rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [slpa_pkg::APB_AW-1:0]   paddr,
    input  logic [slpa_pkg::APB_DW-1:0]   pwdata,
    input  logic                          pready,
    output int                            fail_count,
    output int                            pending
);
    import slpa_pkg::*;

    localparam int DEPTH = POOL_DEPTH_DEF;

    logic [3:0]  link_mem [DEPTH];
    logic [3:0]  free_head;
    logic [3:0]  chain_tail;
    int unsigned use_count;
    int unsigned pool_size;
    rsp_t        expected_rsp [$];

    function automatic void pool_reinit(input logic [4:0] value);
        int unsigned sz;
        sz = 32'(value);
        if (sz < 1)
            sz = 1;
        if (sz > DEPTH)
            sz = DEPTH;
        pool_size = sz;
        for (int i = 0; i < DEPTH; i++)
            link_mem[i] = (i + 1 < sz) ? 4'(i + 1) : 4'd0;
        free_head  = '0;
        chain_tail = '0;
        use_count  = 1;
    endfunction

    function automatic logic [3:0] walk_links(input int unsigned steps);
        logic [3:0] s;
        s = '0;
        for (int unsigned k = 0; k < steps; k++)
            s = link_mem[s];
        return s;
    endfunction

    function automatic rsp_t apply_cmd(input cmd_t c);
        rsp_t        r;
        logic [3:0]  taken;
        logic [3:0]  old_tail;
        int unsigned pos;
        r.slot_index = '0;
        r.status     = STATUS_OK;
        pos          = 32'(c.position);
        case (c.func)
            FUNC_ALLOC:
            begin
                if (use_count + 1 > pool_size)
                begin
                    r.status = STATUS_RANGE;
                end
                else
                begin
                    taken              = free_head;
                    old_tail           = chain_tail;
                    chain_tail         = taken;
                    free_head          = link_mem[taken];
                    link_mem[old_tail] = taken;
                    link_mem[taken]    = '0;
                    use_count++;
                    r.slot_index       = taken;
                end
            end
            FUNC_FREE:
            begin
                if (use_count == 0)
                begin
                    r.status = STATUS_EMPTY;
                end
                else if (pos >= pool_size)
                begin
                    r.status = STATUS_RANGE;
                end
                else
                begin
                    link_mem[pos] = free_head;
                    free_head     = 4'(pos);
                    use_count--;
                end
            end
            default:
            begin
                if (pos > pool_size)
                    r.status = STATUS_RANGE;
                else
                    r.slot_index = walk_links(c.func == FUNC_GET ? pos : pos + 1);
            end
        endcase
        return r;
    endfunction

    function automatic int check_rsp(input rsp_t got, input rsp_t want);
        int n;
        n = 0;
        if (got.slot_index !== want.slot_index)
        begin
            $error("slot_index: expected %0d, got %0d", want.slot_index, got.slot_index);
            n++;
        end
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            n++;
        end
        return n;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        int   n;
        rsp_t want;
        if (!rst_n)
        begin
            pool_reinit(5'(SIZE_RST_VAL));
            expected_rsp.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            n = 0;
            if (done)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $error("result word with no command outstanding: slot_index %0d, status %0d",
                           rsp.slot_index, rsp.status);
                    n = 1;
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    n    = check_rsp(rsp, want);
                end
            end
            if (start && !busy)
                expected_rsp.push_back(apply_cmd(cmd));
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00
                && paddr[APB_AW-1:2] == REG_POOL_SIZE)
                pool_reinit(pwdata[4:0]);
            fail_count <= fail_count + n;
            pending    <= expected_rsp.size();
        end
    end

endmodule

@@ dv/testbench.sv @@
// Top of the static link pool allocator testbench: clock, reset, command and APB
// stimulus under three idle profiles, and the verdict.
// Depends on slpa_pkg, static_link_pool_allocator_core and slpa_checker.
module testbench;
    import slpa_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    cmd_t                cmd;
    logic                done;
    rsp_t                rsp;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    int                  fail_count;
    int                  pending;

    int                  idle_pct;
    int                  cur_size;
    int                  alloc_pct;
    int                  n_cmds;
    int                  n_writes;

    static_link_pool_allocator_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .done    (done),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    slpa_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .done       (done),
        .rsp        (rsp),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("** static_link_pool_allocator_core: FAILED **");
        $finish;
    end

    task automatic send_cmd(input logic [1:0] func, input logic [4:0] position);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start        <= 1'b0;
            cmd.func     <= 2'($urandom);
            cmd.position <= 5'($urandom);
            @(negedge clk);
        end
        start        <= 1'b1;
        cmd.func     <= func;
        cmd.position <= position;
        do
            @(posedge clk);
        while (busy);
        n_cmds++;
    endtask

    task automatic drain;
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_pool_size(input logic [4:0] value);
        drain();
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_POOL_SIZE, 2'b00};
        pwdata  <= APB_DW'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_size = (value == 0) ? 1 : (value > POOL_DEPTH_DEF) ? POOL_DEPTH_DEF : int'(value);
        n_writes++;
    endtask

    task automatic random_cmd;
        int         r;
        logic [4:0] pos;
        r = $urandom_range(99);
        if ($urandom_range(9) == 0)
            pos = 5'($urandom);
        else
            pos = 5'($urandom_range(0, cur_size + 1));
        if (r < alloc_pct)
            send_cmd(FUNC_ALLOC, 5'($urandom));
        else if (r < alloc_pct + (100 - alloc_pct) / 2)
            send_cmd(FUNC_FREE, pos);
        else if (r % 2 == 0)
            send_cmd(FUNC_GET, pos);
        else
            send_cmd(FUNC_NEXT, pos);
    endtask

    function automatic logic [4:0] pick_size();
        case ($urandom_range(9))
            0:       return 5'($urandom_range(17, 31));
            1:       return 5'd0;
            2:       return 5'd16;
            3:       return 5'd1;
            default: return 5'($urandom_range(1, 16));
        endcase
    endfunction

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        cmd      = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        idle_pct = 11;
        cur_size = SIZE_RST_VAL;
        n_cmds   = 0;
        n_writes = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_cmd(FUNC_GET, 5'd16);
        send_cmd(FUNC_NEXT, 5'd17);
        write_pool_size(5'd4);
        send_cmd(FUNC_GET, 5'd0);
        send_cmd(FUNC_NEXT, 5'd0);
        send_cmd(FUNC_GET, 5'd4);
        send_cmd(FUNC_NEXT, 5'd4);
        send_cmd(FUNC_GET, 5'd5);
        for (int i = 0; i < 4; i++)
            send_cmd(FUNC_ALLOC, 5'd31);
        send_cmd(FUNC_NEXT, 5'd2);
        send_cmd(FUNC_FREE, 5'd4);
        send_cmd(FUNC_FREE, 5'd31);
        send_cmd(FUNC_FREE, 5'd2);
        send_cmd(FUNC_FREE, 5'd1);
        send_cmd(FUNC_FREE, 5'd3);
        send_cmd(FUNC_FREE, 5'd0);
        send_cmd(FUNC_FREE, 5'd0);
        send_cmd(FUNC_ALLOC, 5'd0);
        send_cmd(FUNC_GET, 5'd31);
        write_pool_size(5'd0);
        send_cmd(FUNC_ALLOC, 5'd0);
        send_cmd(FUNC_GET, 5'd1);
        send_cmd(FUNC_NEXT, 5'd1);
        write_pool_size(5'd31);
        send_cmd(FUNC_NEXT, 5'd16);

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 11 : (phase == 1) ? 86 : 0;
            for (int seg = 0; seg < 6; seg++)
            begin
                write_pool_size(pick_size());
                alloc_pct = $urandom_range(20, 60);
                for (int k = 0; k < 45; k++)
                begin
                    if ($urandom_range(99) == 0)
                        drain();
                    random_cmd();
                end
            end
        end

        drain();
        repeat (20) @(posedge clk);
        $display("Sent %0d commands over %0d pool size writes, idle profiles 11%%, 86%% and 0%%.",
                 n_cmds, n_writes);
        if (fail_count == 0 && pending == 0)
            $display("** static_link_pool_allocator_core: PASSED **");
        else
            $display("** static_link_pool_allocator_core: FAILED **");
        $finish;
    end

endmodule
